>>> rtl/qou_pkg.sv
// Package for the quaternion orientation unit: beat types, codes and microcode tables.
package qou_pkg;

  // Fixed widths of the datapath
  localparam int QW     = 16;  // quaternion component, Q2.14
  localparam int VW     = 32;  // vector coordinate, Q16.16
  localparam int MW     = 20;  // rounded rotation matrix entry, Q6.14 signed
  localparam int PW     = MW + VW;  // multiplier product
  localparam int AW     = 56;  // accumulator
  localparam int STEP_W = 5;

  localparam logic [STEP_W-1:0] COMPOSE_LAST = STEP_W'(15);
  localparam logic [STEP_W-1:0] ROTATE_LAST  = STEP_W'(26);

  // Item kinds; code 3 is ignored
  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_COMPOSE = 2'd1,
    KIND_ROTATE  = 2'd2
  } kind_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Multiplier operand A: held components or matrix entries
  typedef enum logic [3:0] {
    OPA_HW, OPA_HI, OPA_HJ, OPA_HK,
    OPA_M0, OPA_M1, OPA_M2, OPA_M3, OPA_M4, OPA_M5, OPA_M6, OPA_M7, OPA_M8
  } opa_t;

  // Multiplier operand B: input quaternion, held components or input vector
  typedef enum logic [3:0] {
    OPB_QW, OPB_QI, OPB_QJ, OPB_QK,
    OPB_HW, OPB_HI, OPB_HJ, OPB_HK,
    OPB_VX, OPB_VY, OPB_VZ
  } opb_t;

  // Where a finished accumulation goes
  typedef enum logic [1:0] {
    DST_NONE,
    DST_Q,
    DST_M,
    DST_R
  } dst_t;

  typedef struct packed {
    opa_t       opa;
    opb_t       opb;
    logic       neg;
    dst_t       dst;
    logic [3:0] idx;
  } uop_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_i;
    logic signed [15:0] quat_j;
    logic signed [15:0] quat_k;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [15:0] held_w;
    logic signed [15:0] held_i;
    logic signed [15:0] held_j;
    logic signed [15:0] held_k;
    logic               saturated;
  } rsp_t;

  function automatic uop_t uop_make(opa_t a, opb_t b, logic neg, dst_t dst,
                                    logic [3:0] idx);
    uop_t u;
    u.opa = a;
    u.opb = b;
    u.neg = neg;
    u.dst = dst;
    u.idx = idx;
    return u;
  endfunction

  // Hamilton product, held quaternion on the left
  function automatic uop_t compose_uop(logic [STEP_W-1:0] step);
    uop_t u;
    unique case (step)
      5'd0:    u = uop_make(OPA_HW, OPB_QW, 1'b0, DST_NONE, 4'd0);
      5'd1:    u = uop_make(OPA_HI, OPB_QI, 1'b1, DST_NONE, 4'd0);
      5'd2:    u = uop_make(OPA_HJ, OPB_QJ, 1'b1, DST_NONE, 4'd0);
      5'd3:    u = uop_make(OPA_HK, OPB_QK, 1'b1, DST_Q,    4'd0);
      5'd4:    u = uop_make(OPA_HW, OPB_QI, 1'b0, DST_NONE, 4'd0);
      5'd5:    u = uop_make(OPA_HI, OPB_QW, 1'b0, DST_NONE, 4'd0);
      5'd6:    u = uop_make(OPA_HJ, OPB_QK, 1'b0, DST_NONE, 4'd0);
      5'd7:    u = uop_make(OPA_HK, OPB_QJ, 1'b1, DST_Q,    4'd1);
      5'd8:    u = uop_make(OPA_HW, OPB_QJ, 1'b0, DST_NONE, 4'd0);
      5'd9:    u = uop_make(OPA_HI, OPB_QK, 1'b1, DST_NONE, 4'd0);
      5'd10:   u = uop_make(OPA_HJ, OPB_QW, 1'b0, DST_NONE, 4'd0);
      5'd11:   u = uop_make(OPA_HK, OPB_QI, 1'b0, DST_Q,    4'd2);
      5'd12:   u = uop_make(OPA_HW, OPB_QK, 1'b0, DST_NONE, 4'd0);
      5'd13:   u = uop_make(OPA_HI, OPB_QJ, 1'b0, DST_NONE, 4'd0);
      5'd14:   u = uop_make(OPA_HJ, OPB_QI, 1'b1, DST_NONE, 4'd0);
      5'd15:   u = uop_make(OPA_HK, OPB_QW, 1'b0, DST_Q,    4'd3);
      default: u = uop_make(OPA_HW, OPB_QW, 1'b0, DST_NONE, 4'd0);
    endcase
    return u;
  endfunction

  // Matrix entries from pairwise products, then matrix times vector
  function automatic uop_t rotate_uop(logic [STEP_W-1:0] step);
    uop_t u;
    unique case (step)
      // m00 = -cc - dd
      5'd0:    u = uop_make(OPA_HJ, OPB_HJ, 1'b1, DST_NONE, 4'd0);
      5'd1:    u = uop_make(OPA_HK, OPB_HK, 1'b1, DST_M,    4'd0);
      // m01 = bc - ad
      5'd2:    u = uop_make(OPA_HI, OPB_HJ, 1'b0, DST_NONE, 4'd0);
      5'd3:    u = uop_make(OPA_HW, OPB_HK, 1'b1, DST_M,    4'd1);
      // m02 = ac + bd
      5'd4:    u = uop_make(OPA_HW, OPB_HJ, 1'b0, DST_NONE, 4'd0);
      5'd5:    u = uop_make(OPA_HI, OPB_HK, 1'b0, DST_M,    4'd2);
      // m10 = ad + bc
      5'd6:    u = uop_make(OPA_HW, OPB_HK, 1'b0, DST_NONE, 4'd0);
      5'd7:    u = uop_make(OPA_HI, OPB_HJ, 1'b0, DST_M,    4'd3);
      // m11 = -bb - dd
      5'd8:    u = uop_make(OPA_HI, OPB_HI, 1'b1, DST_NONE, 4'd0);
      5'd9:    u = uop_make(OPA_HK, OPB_HK, 1'b1, DST_M,    4'd4);
      // m12 = cd - ab
      5'd10:   u = uop_make(OPA_HJ, OPB_HK, 1'b0, DST_NONE, 4'd0);
      5'd11:   u = uop_make(OPA_HW, OPB_HI, 1'b1, DST_M,    4'd5);
      // m20 = bd - ac
      5'd12:   u = uop_make(OPA_HI, OPB_HK, 1'b0, DST_NONE, 4'd0);
      5'd13:   u = uop_make(OPA_HW, OPB_HJ, 1'b1, DST_M,    4'd6);
      // m21 = ab + cd
      5'd14:   u = uop_make(OPA_HW, OPB_HI, 1'b0, DST_NONE, 4'd0);
      5'd15:   u = uop_make(OPA_HJ, OPB_HK, 1'b0, DST_M,    4'd7);
      // m22 = -bb - cc
      5'd16:   u = uop_make(OPA_HI, OPB_HI, 1'b1, DST_NONE, 4'd0);
      5'd17:   u = uop_make(OPA_HJ, OPB_HJ, 1'b1, DST_M,    4'd8);
      // rows of M * v
      5'd18:   u = uop_make(OPA_M0, OPB_VX, 1'b0, DST_NONE, 4'd0);
      5'd19:   u = uop_make(OPA_M1, OPB_VY, 1'b0, DST_NONE, 4'd0);
      5'd20:   u = uop_make(OPA_M2, OPB_VZ, 1'b0, DST_R,    4'd0);
      5'd21:   u = uop_make(OPA_M3, OPB_VX, 1'b0, DST_NONE, 4'd0);
      5'd22:   u = uop_make(OPA_M4, OPB_VY, 1'b0, DST_NONE, 4'd0);
      5'd23:   u = uop_make(OPA_M5, OPB_VZ, 1'b0, DST_R,    4'd1);
      5'd24:   u = uop_make(OPA_M6, OPB_VX, 1'b0, DST_NONE, 4'd0);
      5'd25:   u = uop_make(OPA_M7, OPB_VY, 1'b0, DST_NONE, 4'd0);
      5'd26:   u = uop_make(OPA_M8, OPB_VZ, 1'b0, DST_R,    4'd2);
      default: u = uop_make(OPA_HW, OPB_QW, 1'b0, DST_NONE, 4'd0);
    endcase
    return u;
  endfunction

endpackage

>>> rtl/quaternion_orientation_unit_top.sv
// Quaternion orientation unit: held quaternion with load, compose and rotate on one multiplier.
//
//   channel | direction | handshake              | beat
//   req     | in        | req_valid / req_ready  | qou_pkg::req_t
//   rsp     | out       | rsp_valid / rsp_ready  | qou_pkg::rsp_t
//
// A load or ignored kind goes from idle straight to the done state; a compose or a rotate
// runs first: one 20x32 signed multiplier does one product per cycle (16 for a
// compose, 18 for the matrix plus 9 for the vector), followed by a drain state.
// req_ready is high only while the sequencer is idle; a result may still wait in the
// rsp register then. A finished item waits for that register to empty.
// Synchronous reset loads the identity quaternion and empties the rsp register.
module quaternion_orientation_unit_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  qou_pkg::req_t  req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output qou_pkg::rsp_t  rsp
);

  localparam logic signed [qou_pkg::AW-1:0] RND14  = qou_pkg::AW'(8192);
  localparam logic signed [qou_pkg::AW-1:0] RND13  = qou_pkg::AW'(4096);
  localparam logic signed [qou_pkg::AW-1:0] Q_MAX  = qou_pkg::AW'(32767);
  localparam logic signed [qou_pkg::AW-1:0] Q_MIN  = -qou_pkg::AW'(32768);
  localparam logic signed [qou_pkg::AW-1:0] V_MAX  = qou_pkg::AW'(64'sd2147483647);
  localparam logic signed [qou_pkg::AW-1:0] V_MIN  = -qou_pkg::AW'(64'sd2147483648);

  qou_pkg::state_t state, state_next;
  logic [qou_pkg::STEP_W-1:0] step;
  logic finish;
  logic accept;

  qou_pkg::req_t item;
  logic signed [qou_pkg::QW-1:0] held [4];
  logic signed [qou_pkg::QW-1:0] qn [4];
  logic signed [qou_pkg::MW-1:0] mreg [9];
  logic signed [qou_pkg::VW-1:0] rrow [3];
  logic sat;

  // multiplier pipeline
  qou_pkg::uop_t uop, ptag;
  logic pv;
  logic signed [qou_pkg::MW-1:0] opa_val;
  logic signed [qou_pkg::VW-1:0] opb_val;
  logic signed [qou_pkg::PW-1:0] prod;
  logic signed [qou_pkg::AW-1:0] acc, addend, sum;
  logic signed [qou_pkg::AW-1:0] sh14, row_val;
  logic signed [qou_pkg::AW-1:0] rnd13;
  logic signed [qou_pkg::VW-1:0] vsel;
  logic signed [qou_pkg::QW-1:0] q_clamped;
  logic signed [qou_pkg::VW-1:0] r_clamped;
  logic q_ovf, r_ovf, sat_hit;
  logic signed [qou_pkg::QW-1:0] held_new [4];
  logic is_rot;

  assign accept = req_valid && req_ready;
  assign is_rot = (item.kind == qou_pkg::KIND_ROTATE);

  // Sequencer next state and handshake
  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    finish     = 1'b0;
    unique case (state)
      qou_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req.kind == qou_pkg::KIND_COMPOSE || req.kind == qou_pkg::KIND_ROTATE) begin
            state_next = qou_pkg::ST_RUN;
          end else begin
            state_next = qou_pkg::ST_DONE;
          end
        end
      end
      qou_pkg::ST_RUN: begin
        if (step == (is_rot ? qou_pkg::ROTATE_LAST : qou_pkg::COMPOSE_LAST)) begin
          state_next = qou_pkg::ST_DRAIN;
        end
      end
      qou_pkg::ST_DRAIN: begin
        state_next = qou_pkg::ST_DONE;
      end
      qou_pkg::ST_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          finish     = 1'b1;
          state_next = qou_pkg::ST_IDLE;
        end
      end
      default: state_next = qou_pkg::ST_IDLE;
    endcase
  end

  // Microcode and operand selection
  always_comb begin
    uop = is_rot ? qou_pkg::rotate_uop(step) : qou_pkg::compose_uop(step);
    unique case (uop.opa)
      qou_pkg::OPA_HW: opa_val = qou_pkg::MW'(held[0]);
      qou_pkg::OPA_HI: opa_val = qou_pkg::MW'(held[1]);
      qou_pkg::OPA_HJ: opa_val = qou_pkg::MW'(held[2]);
      qou_pkg::OPA_HK: opa_val = qou_pkg::MW'(held[3]);
      qou_pkg::OPA_M0: opa_val = mreg[0];
      qou_pkg::OPA_M1: opa_val = mreg[1];
      qou_pkg::OPA_M2: opa_val = mreg[2];
      qou_pkg::OPA_M3: opa_val = mreg[3];
      qou_pkg::OPA_M4: opa_val = mreg[4];
      qou_pkg::OPA_M5: opa_val = mreg[5];
      qou_pkg::OPA_M6: opa_val = mreg[6];
      qou_pkg::OPA_M7: opa_val = mreg[7];
      qou_pkg::OPA_M8: opa_val = mreg[8];
      default:         opa_val = '0;
    endcase
    unique case (uop.opb)
      qou_pkg::OPB_QW: opb_val = qou_pkg::VW'(item.quat_w);
      qou_pkg::OPB_QI: opb_val = qou_pkg::VW'(item.quat_i);
      qou_pkg::OPB_QJ: opb_val = qou_pkg::VW'(item.quat_j);
      qou_pkg::OPB_QK: opb_val = qou_pkg::VW'(item.quat_k);
      qou_pkg::OPB_HW: opb_val = qou_pkg::VW'(held[0]);
      qou_pkg::OPB_HI: opb_val = qou_pkg::VW'(held[1]);
      qou_pkg::OPB_HJ: opb_val = qou_pkg::VW'(held[2]);
      qou_pkg::OPB_HK: opb_val = qou_pkg::VW'(held[3]);
      qou_pkg::OPB_VX: opb_val = item.vec_x;
      qou_pkg::OPB_VY: opb_val = item.vec_y;
      qou_pkg::OPB_VZ: opb_val = item.vec_z;
      default:         opb_val = '0;
    endcase
  end

  // Accumulate, round and clamp
  always_comb begin
    addend  = ptag.neg ? -qou_pkg::AW'(prod) : qou_pkg::AW'(prod);
    sum     = acc + addend;
    sh14    = (sum + RND14) >>> 14;
    rnd13   = sum + RND13;
    unique case (ptag.idx[1:0])
      2'd0:    vsel = item.vec_x;
      2'd1:    vsel = item.vec_y;
      2'd2:    vsel = item.vec_z;
      default: vsel = '0;
    endcase
    row_val = sh14 + qou_pkg::AW'(vsel);
    q_ovf   = (sh14 > Q_MAX) || (sh14 < Q_MIN);
    r_ovf   = (row_val > V_MAX) || (row_val < V_MIN);
    priority if (sh14 > Q_MAX) begin
      q_clamped = qou_pkg::QW'(Q_MAX);
    end else if (sh14 < Q_MIN) begin
      q_clamped = qou_pkg::QW'(Q_MIN);
    end else begin
      q_clamped = sh14[qou_pkg::QW-1:0];
    end
    priority if (row_val > V_MAX) begin
      r_clamped = qou_pkg::VW'(V_MAX);
    end else if (row_val < V_MIN) begin
      r_clamped = qou_pkg::VW'(V_MIN);
    end else begin
      r_clamped = row_val[qou_pkg::VW-1:0];
    end
    sat_hit = pv && ((ptag.dst == qou_pkg::DST_Q && q_ovf) ||
                     (ptag.dst == qou_pkg::DST_R && r_ovf));
  end

  // Held quaternion after this item
  always_comb begin
    if (item.kind == qou_pkg::KIND_LOAD) begin
      held_new[0] = item.quat_w;
      held_new[1] = item.quat_i;
      held_new[2] = item.quat_j;
      held_new[3] = item.quat_k;
    end else if (item.kind == qou_pkg::KIND_COMPOSE) begin
      held_new = qn;
    end else begin
      held_new = held;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= qou_pkg::ST_IDLE;
      step      <= '0;
      pv        <= 1'b0;
      acc       <= '0;
      rsp_valid <= 1'b0;
      held[0]   <= qou_pkg::QW'(16384);
      held[1]   <= '0;
      held[2]   <= '0;
      held[3]   <= '0;
    end else begin
      state <= state_next;
      pv    <= (state == qou_pkg::ST_RUN);
      step  <= (state == qou_pkg::ST_RUN) ? step + 1'b1 : '0;
      if (pv) begin
        acc <= (ptag.dst == qou_pkg::DST_NONE) ? sum : '0;
      end
      if (finish) begin
        rsp_valid <= 1'b1;
        held      <= held_new;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
      sat  <= 1'b0;
    end else if (sat_hit) begin
      sat <= 1'b1;
    end
    if (state == qou_pkg::ST_RUN) begin
      ptag <= uop;
      prod <= opa_val * opb_val;
    end
    if (pv) begin
      unique case (ptag.dst)
        qou_pkg::DST_Q:    qn[ptag.idx[1:0]] <= q_clamped;
        qou_pkg::DST_M:    mreg[ptag.idx]    <= rnd13[qou_pkg::MW+12:13];
        qou_pkg::DST_R:    rrow[ptag.idx[1:0]] <= r_clamped;
        qou_pkg::DST_NONE: ;
        default: ;
      endcase
    end
    if (finish) begin
      rsp.out_x     <= is_rot ? rrow[0] : '0;
      rsp.out_y     <= is_rot ? rrow[1] : '0;
      rsp.out_z     <= is_rot ? rrow[2] : '0;
      rsp.held_w    <= held_new[0];
      rsp.held_i    <= held_new[1];
      rsp.held_j    <= held_new[2];
      rsp.held_k    <= held_new[3];
      rsp.saturated <= sat;
    end
  end

endmodule

>>> rtl/qou_checker.sv
// Port-level checks for the quaternion orientation unit, bound to the top level.
module qou_port_checks (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input qou_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input qou_pkg::rsp_t rsp
);

  logic [1:0] pending;
  logic       req_beat, rsp_beat;

  assign req_beat = req_valid && req_ready;
  assign rsp_beat = rsp_valid && rsp_ready;

  // Items taken in but whose result beat has not gone out
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(req_beat) - 2'(rsp_beat);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp_valid high after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled rsp beat changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_beat |=> !req_ready)
    else $error("req_ready high right after an accepted beat");

  a_no_orphan_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("rsp beat with no item outstanding");

  a_two_in_flight: assert property (@(posedge clk) disable iff (rst)
    pending == 2'd2 |-> !req_ready)
    else $error("third item accepted while two outstanding");

endmodule

bind quaternion_orientation_unit_top qou_port_checks u_qou_checker (.*);

>>> bench/qou_checker.sv
// Checker for the quaternion orientation unit: tracks the held quaternion and compares every result beat.
module qou_checker
  import qou_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   errors,
  output int   pending,
  output int   checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted orientation, Q2.14 per component (w, i, j, k)
  logic signed [15:0] held_q [4];
  rsp_t               orient_results [$];
  int                 err_count;
  int                 cmp_count;

  // Shift right with round to nearest, ties toward +inf
  function automatic longint rnd_shift(input longint x, input int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(input longint x, input longint lo, input longint hi,
                                  inout bit sat);
    if (x < lo) begin
      sat = 1'b1;
      return lo;
    end
    if (x > hi) begin
      sat = 1'b1;
      return hi;
    end
    return x;
  endfunction

  // Apply one request beat to the held quaternion, return the result beat it produces
  function automatic rsp_t orient_step(input req_t beat);
    rsp_t   r;
    longint a, b, c, d;
    longint q [4];
    longint v [3];
    longint p [4];
    longint m [9];
    longint res [3];
    longint ab, ac, ad, bb, bc, bd, cc, cd, dd, acc;
    bit     sat;
    sat = 1'b0;
    q[0] = beat.quat_w;
    q[1] = beat.quat_i;
    q[2] = beat.quat_j;
    q[3] = beat.quat_k;
    v[0] = beat.vec_x;
    v[1] = beat.vec_y;
    v[2] = beat.vec_z;
    a = held_q[0];
    b = held_q[1];
    c = held_q[2];
    d = held_q[3];
    for (int n = 0; n < 3; n++) res[n] = 0;
    case (beat.kind)
      KIND_LOAD: begin
        for (int n = 0; n < 4; n++) held_q[n] = q[n][15:0];
      end
      KIND_COMPOSE: begin
        // Hamilton product, held on the left
        p[0] = a * q[0] - b * q[1] - c * q[2] - d * q[3];
        p[1] = a * q[1] + b * q[0] + c * q[3] - d * q[2];
        p[2] = a * q[2] - b * q[3] + c * q[0] + d * q[1];
        p[3] = a * q[3] + b * q[2] - c * q[1] + d * q[0];
        for (int n = 0; n < 4; n++)
          held_q[n] = 16'(clip(rnd_shift(p[n], 14), -32768, 32767, sat));
      end
      KIND_ROTATE: begin
        ab = a * b;
        ac = a * c;
        ad = a * d;
        bb = -(b * b);
        bc = b * c;
        bd = b * d;
        cc = -(c * c);
        cd = c * d;
        dd = -(d * d);
        m[0] = cc + dd; m[1] = bc - ad; m[2] = ac + bd;
        m[3] = ad + bc; m[4] = bb + dd; m[5] = cd - ab;
        m[6] = bd - ac; m[7] = ab + cd; m[8] = bb + cc;
        // v' = v + 2*(M*v); entries rounded to 14 fraction bits first
        for (int n = 0; n < 3; n++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += rnd_shift(m[3 * n + k], 13) * v[k];
          res[n] = clip(v[n] + rnd_shift(acc, 14), -64'sd2147483648, 64'sd2147483647, sat);
        end
      end
      default: ;  // unused kind leaves the state alone
    endcase
    r.out_x     = 32'(res[0]);
    r.out_y     = 32'(res[1]);
    r.out_z     = 32'(res[2]);
    r.held_w    = held_q[0];
    r.held_i    = held_q[1];
    r.held_j    = held_q[2];
    r.held_k    = held_q[3];
    r.saturated = sat;
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  // Predict on accepted requests, compare on accepted results
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      held_q[0] = 16'sd16384;
      held_q[1] = '0;
      held_q[2] = '0;
      held_q[3] = '0;
      orient_results.delete();
      err_count = 0;
      cmp_count = 0;
    end else begin
      if (req_valid && req_ready) orient_results.push_back(orient_step(req));
      if (rsp_valid && rsp_ready) begin
        if (orient_results.size() == 0) begin
          $error("result beat with no prediction waiting");
          err_count++;
        end else begin
          want = orient_results.pop_front();
          check_field("out_x", want.out_x, rsp.out_x);
          check_field("out_y", want.out_y, rsp.out_y);
          check_field("out_z", want.out_z, rsp.out_z);
          check_field("held_w", want.held_w, rsp.held_w);
          check_field("held_i", want.held_i, rsp.held_i);
          check_field("held_j", want.held_j, rsp.held_j);
          check_field("held_k", want.held_k, rsp.held_k);
          check_field("saturated", want.saturated, rsp.saturated);
          cmp_count++;
        end
      end
    end
    errors  <= err_count;
    pending <= orient_results.size();
    checked <= cmp_count;
  end

endmodule

>>> bench/tb.sv
// Testbench top for the quaternion orientation unit: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import qou_pkg::*;

  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam int         HOLD_CYCLES  = 250;
  localparam int         STALL_LIMIT  = 3000;
  localparam int         DRAIN_CYCLES = 40;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_ready = 1'b0;
  req_t req       = '0;
  logic req_ready;
  logic rsp_valid;
  rsp_t rsp;
  int   errors;
  int   pending;
  int   checked;
  bit   quiet    = 1'b0;  // no idling on either side
  bit   hold_req = 1'b0;  // ask the receiver for one long hold-off
  int   n_sent [4];
  int   idle_run = 0;

  quaternion_orientation_unit_top DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  qou_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_run <= 0;
    end else if (idle_run >= STALL_LIMIT) begin
      $display("quaternion_orientation_unit_top verification failed");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 13);
        if (stall > 0) begin
          rsp_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
    end
  end

  function automatic logic [15:0] pick_comp();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(0, 32768)) - 16384);
      2: begin
        case ($urandom_range(0, 5))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          3: return 16'h4000;
          4: return 16'hc000;
          default: return 16'hffff;
        endcase
      end
      default: return 16'(int'($urandom_range(0, 4096)) - 2048);
    endcase
  endfunction

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          3: return 32'hffff_ffff;
          default: return 32'h0001_0000;
        endcase
      end
      default: return 32'(int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
    endcase
  endfunction

  function automatic req_t mk(input logic [1:0] kind, input logic [15:0] w, input logic [15:0] i,
                              input logic [15:0] j, input logic [15:0] k, input logic [31:0] x,
                              input logic [31:0] y, input logic [31:0] z);
    req_t b;
    b.kind   = kind;
    b.quat_w = w;
    b.quat_i = i;
    b.quat_j = j;
    b.quat_k = k;
    b.vec_x  = x;
    b.vec_y  = y;
    b.vec_z  = z;
    return b;
  endfunction

  // Random payload; full-width noise or shaped values
  function automatic req_t rand_beat(input logic [1:0] kind, input bit noise);
    if (noise)
      return mk(kind, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                $urandom, $urandom, $urandom);
    return mk(kind, pick_comp(), pick_comp(), pick_comp(), pick_comp(),
              pick_coord(), pick_coord(), pick_coord());
  endfunction

  task automatic send_beat(input req_t beat);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= beat;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    n_sent[beat.kind]++;
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly load-then-compose/rotate chains, some noise of any kind
  task automatic run_random(input int count);
    int         done_n;
    int         len;
    logic [1:0] kind;
    done_n = 0;
    while (done_n < count) begin
      if ($urandom_range(0, 9) < 2) begin
        kind = 2'($urandom_range(0, 3));
        send_beat(rand_beat(kind, 1'b1));
        if (kind != KIND_UNUSED) done_n++;
      end else begin
        send_beat(rand_beat(KIND_LOAD, 1'b0));
        done_n++;
        len = $urandom_range(1, 6);
        repeat (len) begin
          kind = ($urandom_range(0, 99) < 65) ? KIND_ROTATE : KIND_COMPOSE;
          send_beat(rand_beat(kind, 1'b0));
          done_n++;
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: identity, extremes, saturation, zero quaternion, quarter turns, ignored kind
    send_beat(mk(KIND_ROTATE, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000));
    send_beat(mk(KIND_LOAD, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 0, 0, 0));
    send_beat(mk(KIND_ROTATE, 0, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff));
    send_beat(mk(KIND_COMPOSE, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0));
    send_beat(rand_beat(KIND_UNUSED, 1'b1));
    send_beat(mk(KIND_LOAD, 0, 0, 0, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    send_beat(mk(KIND_ROTATE, 0, 0, 0, 0, 32'd123456, -32'sd654321, 32'd1));
    send_beat(mk(KIND_LOAD, 16'd11585, 0, 0, 16'd11585, 0, 0, 0));
    send_beat(mk(KIND_ROTATE, 0, 0, 0, 0, 32'h0001_0000, 0, 0));
    send_beat(mk(KIND_COMPOSE, 16'd11585, 16'd11585, 0, 0, 0, 0, 0));
    send_beat(mk(KIND_ROTATE, 0, 0, 0, 0, 0, 32'h0001_0000, 32'hffff_0000));
    send_beat(mk(KIND_LOAD, 16'd16384, 0, 0, 0, 0, 0, 0));
    send_beat(mk(KIND_COMPOSE, 16'd16384, 0, 0, 0, 0, 0, 0));
    send_beat(mk(KIND_ROTATE, 0, 0, 0, 0, 32'd1, 32'hffff_ffff, 32'h7fff_ffff));
    send_beat(mk(KIND_LOAD, 16'hc000, 0, 0, 0, 0, 0, 0));
    send_beat(mk(KIND_COMPOSE, 0, 16'd16384, 0, 0, 0, 0, 0));
    send_beat(mk(KIND_ROTATE, 0, 0, 0, 0, 32'h8000_0000, 32'h0001_8000, 32'hfffe_8000));
    send_beat(mk(KIND_UNUSED, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    send_beat(mk(KIND_LOAD, 16'd8192, 16'd8192, 16'd8192, 16'd8192, 0, 0, 0));
    send_beat(mk(KIND_ROTATE, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
    send_beat(mk(KIND_COMPOSE, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 0));
    send_beat(mk(KIND_ROTATE, 0, 0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));

    run_random(400);

    // Back-to-back stretch with no idling
    quiet = 1'b1;
    run_random(150);

    // Receiver holds off while the sender keeps offering
    hold_req = 1'b1;
    run_random(25);
    quiet = 1'b0;
    wait_drained();

    run_random(425);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d loads, %0d composes, %0d rotates, %0d ignored beats",
             n_sent[KIND_LOAD], n_sent[KIND_COMPOSE], n_sent[KIND_ROTATE], n_sent[KIND_UNUSED]);
    $display("%0d result beats compared, %0d mismatches", checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("quaternion_orientation_unit_top verification clean");
    end else begin
      $display("quaternion_orientation_unit_top verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/qou_pkg.sv
rtl/quaternion_orientation_unit_top.sv
rtl/qou_checker.sv
bench/qou_checker.sv
bench/tb.sv
